// ----- hdl/dpr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpr_pkg - shared types and constants of the debug packet receiver
// Holds the result kinds, framing characters and the result bundle that
// travels from the frame decoder to the output serializer.
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int MAX_RESULTS = 4;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_TX       = 3'd1,
        KIND_ACCEPT   = 3'd2,
        KIND_RESTART  = 3'd3,
        KIND_OVERFLOW = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SUM_HI  = 2'd2,
        PH_SUM_LO  = 2'd3
    } t_phase;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [9:0]  index;
        logic [9:0]  length;
        logic [1:0]  offset;
    } t_result;

    // Up to four results from one received byte; cnt is 0..4.
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic    [2:0]             cnt;
    } t_bundle;

endpackage

// ----- hdl/dpr_frame.sv -----
// ----------------------------------------------------------------------------
// dpr_frame - packet framing state and per-byte decode
// Tracks the framing phase, running sum and byte count, and builds the
// bundle of results that one received byte causes.
// ----------------------------------------------------------------------------
module dpr_frame #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic [7:0]      i_byte,
    output dpr_pkg::t_bundle o_bun
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 1);
    localparam logic [CNT_W-1:0] HEAD_N = CNT_W'(3);

    dpr_pkg::t_phase   r_phase, n_phase;
    logic [7:0]        r_sum, n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [4:0]        r_hi, n_hi;
    logic [7:0]        r_head [3];
    logic              head_we;

    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W+9:0]  cur_ext, inc_ext;
    logic [4:0]        lo_val;
    logic              sum_ok;

    // Hex digit value; bit 4 set marks a character that is no hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

    function automatic dpr_pkg::t_result mk(input dpr_pkg::t_kind k,
                                            input logic [7:0] d,
                                            input logic [9:0] idx,
                                            input logic [9:0] len,
                                            input logic [1:0] off);
        dpr_pkg::t_result r;
        r.kind   = k;
        r.data   = d;
        r.index  = idx;
        r.length = len;
        r.offset = off;
        return r;
    endfunction

    assign count_inc = r_count + CNT_W'(1);
    assign cur_ext   = {10'd0, r_count};
    assign inc_ext   = {10'd0, count_inc};
    assign lo_val    = hex_value(i_byte);
    assign sum_ok    = !r_hi[4] && !lo_val[4] && ({r_hi[3:0], lo_val[3:0]} == r_sum);

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_count = r_count;
        n_hi    = r_hi;
        head_we = 1'b0;
        o_bun   = '0;
        unique case (r_phase)
            dpr_pkg::PH_HUNT: begin
                if (i_byte == dpr_pkg::CH_DOLLAR) begin
                    n_sum   = '0;
                    n_count = '0;
                    n_phase = dpr_pkg::PH_PAYLOAD;
                end
            end
            dpr_pkg::PH_PAYLOAD: begin
                priority if (i_byte == dpr_pkg::CH_DOLLAR) begin
                    n_sum      = '0;
                    n_count    = '0;
                    o_bun.res[0] = mk(dpr_pkg::KIND_RESTART, 8'd0, 10'd0, 10'd0, 2'd0);
                    o_bun.cnt  = 3'd1;
                end else if (i_byte == dpr_pkg::CH_HASH) begin
                    n_phase = dpr_pkg::PH_SUM_HI;
                end else begin
                    n_sum      = r_sum + i_byte;
                    n_count    = count_inc;
                    head_we    = (r_count < HEAD_N);
                    o_bun.res[0] = mk(dpr_pkg::KIND_PAYLOAD, i_byte, cur_ext[9:0],
                                      10'd0, 2'd0);
                    o_bun.cnt  = 3'd1;
                    if (count_inc == LIMIT) begin
                        o_bun.res[1] = mk(dpr_pkg::KIND_OVERFLOW, 8'd0, 10'd0,
                                          inc_ext[9:0], 2'd0);
                        o_bun.cnt  = 3'd2;
                        n_phase    = dpr_pkg::PH_HUNT;
                    end
                end
            end
            dpr_pkg::PH_SUM_HI: begin
                n_hi    = lo_val;
                n_phase = dpr_pkg::PH_SUM_LO;
            end
            dpr_pkg::PH_SUM_LO: begin
                n_phase = dpr_pkg::PH_HUNT;
                if (!sum_ok) begin
                    o_bun.res[0] = mk(dpr_pkg::KIND_TX, dpr_pkg::CH_MINUS, 10'd0,
                                      10'd0, 2'd0);
                    o_bun.cnt  = 3'd1;
                end else begin
                    o_bun.res[0] = mk(dpr_pkg::KIND_TX, dpr_pkg::CH_PLUS, 10'd0,
                                      10'd0, 2'd0);
                    if (r_count >= HEAD_N && r_head[2] == dpr_pkg::CH_COLON) begin
                        // echo the sequence id ahead of the accept report
                        o_bun.res[1] = mk(dpr_pkg::KIND_TX, r_head[0], 10'd0,
                                          10'd0, 2'd0);
                        o_bun.res[2] = mk(dpr_pkg::KIND_TX, r_head[1], 10'd0,
                                          10'd0, 2'd0);
                        o_bun.res[3] = mk(dpr_pkg::KIND_ACCEPT, 8'd0, 10'd0,
                                          cur_ext[9:0], 2'd3);
                        o_bun.cnt  = 3'd4;
                    end else begin
                        o_bun.res[1] = mk(dpr_pkg::KIND_ACCEPT, 8'd0, 10'd0,
                                          cur_ext[9:0], 2'd0);
                        o_bun.cnt  = 3'd2;
                    end
                end
            end
            default: n_phase = dpr_pkg::PH_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dpr_pkg::PH_HUNT;
            r_sum   <= '0;
            r_count <= '0;
            r_hi    <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_hi    <= n_hi;
        end
    end

    // Head bytes are only read once three bytes of this packet were stored.
    always_ff @(posedge i_clk) begin
        if (i_adv && head_we) begin
            r_head[r_count[1:0]] <= i_byte;
        end
    end

endmodule

// ----- hdl/dpr_serial.sv -----
// ----------------------------------------------------------------------------
// dpr_serial - result bundle buffer and output serializer
// Holds one bundle and hands its results out one transfer at a time.
// ----------------------------------------------------------------------------
module dpr_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dpr_pkg::t_bundle i_bun,
    output logic             o_free,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output dpr_pkg::t_result o_res,
    output logic             o_last
);

    dpr_pkg::t_bundle r_bun;
    logic             r_valid;
    logic [1:0]       r_ptr;

    assign o_res      = r_bun.res[r_ptr];
    assign o_last     = ({1'b0, r_ptr} + 3'd1) == r_bun.cnt;
    assign o_m_tvalid = r_valid;
    assign o_free     = !r_valid || (i_m_tready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ptr   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_ptr   <= '0;
        end else if (r_valid && i_m_tready) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_ptr <= r_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bun <= i_bun;
        end
    end

endmodule

// ----- hdl/debug_packet_receiver.sv -----
// ----------------------------------------------------------------------------
// debug_packet_receiver - framing receiver for '$' payload '#' hh packets
// Takes received serial bytes, streams payload bytes with their index,
// checks the two-digit hex sum and reports acknowledge, echo and accept.
// ----------------------------------------------------------------------------
// A received byte is held in an input register until the result buffer can
// take its bundle, decoded by the frame logic into zero to four results,
// and those results leave one per transfer from a result buffer. With the
// output never stalled the sustained rate is one byte per cycle for plain
// payload; a byte that causes several results holds the next byte back until
// all of them have left, since there is a single result buffer. The next
// byte is taken in the same cycle as the last result of the previous one
// leaves. Payload lengths wrap to 10 bits; a packet is dropped with an
// overflow report after BUFFER_BYTES-1 payload bytes without '#'.
// ----------------------------------------------------------------------------
module debug_packet_receiver #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] data, [17:8] index, [27:18] length,
                                     // [29:28] payload_offset, [31:30] zero
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast    // last result caused by this byte
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             slot_free;
    logic             adv;
    dpr_pkg::t_bundle bun;
    dpr_pkg::t_result res;

    // Advance the held byte once the result buffer can take its bundle.
    assign adv        = r_in_valid && slot_free;
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    dpr_frame #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_frame (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_byte (r_in_byte),
        .o_bun  (bun)
    );

    // Bytes that cause no result update the state only.
    dpr_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (adv && (bun.cnt != 3'd0)),
        .i_bun     (bun),
        .o_free    (slot_free),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_res     (res),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, res.offset, res.length, res.index, res.data};
    assign o_m_tuser = res.kind;

endmodule
